### rtl/avp_pkg.sv
`default_nettype none

package avp_pkg;

  // Field and register widths
  localparam int COORD_WIDTH  = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int PPR_W        = 16;
  localparam int CTR_W        = 12;
  localparam int SCR_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = (COORD_WIDTH > PPR_W) ? COORD_WIDTH : PPR_W;

  // Datapath widths
  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int FRAC_BITS = 30;
  localparam int MAG_W     = (DIFF_W > FRAC_BITS + 1) ? DIFF_W : FRAC_BITS + 1;
  localparam int CW        = MAG_W + 3;
  localparam int SH_W      = $clog2(FRAC_BITS + 1);
  localparam int ANG_W     = 32;
  localparam int AW1       = ANG_W + 1;
  localparam int PROD_W    = AW1 + PPR_W + 1;
  localparam int Q_W       = PROD_W - FRAC_BITS;
  localparam int SUM_W     = Q_W + 1;

  // Cycles from an accepted request to its result strobe
  localparam int LATENCY = CORDIC_STEPS + 7;

  // Register reset values
  localparam int OFFSET_Z_RST = 61440;
  localparam int PPR_RST      = 1528;
  localparam int CENTER_X_RST = 800;
  localparam int CENTER_Y_RST = 450;

  // Angle constants, radians in Q30
  localparam int TABLE_LEN = 24;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_PPR      = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5
  } cfg_reg_t;

  // Per-angle special-case flags
  typedef struct packed {
    logic zero_num;
    logic num_neg;
    logic flip;
  } lane_flag_t;

  // Sideband that travels with one vertex
  typedef struct packed {
    lane_flag_t [1:0] lane;
    logic             zero_den;
    logic             behind;
  } side_t;

endpackage

`default_nettype wire

### rtl/angular_vertex_projection_unit.sv
// Angular vertex projection: one vertex (signed Q12.12) is taken per clock whenever start is
// high; busy stays low and cfg_ready stays high. The receiver cannot stall, so each result
// appears on the out_ ports for one cycle under out_valid, in request order. A request passes
// three input stages (offset add, magnitude, normalize count), the normalizing shift, the
// vectoring CORDIC with one register stage per iteration, and angle select, multiply and
// saturate stages. Write configuration only while no request is in flight.
`default_nettype none

module angular_vertex_projection_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [avp_pkg::COORD_WIDTH-1:0]  in_vert_x,
  input  logic signed [avp_pkg::COORD_WIDTH-1:0]  in_vert_y,
  input  logic signed [avp_pkg::COORD_WIDTH-1:0]  in_vert_z,
  output logic                                    out_valid,
  output logic signed [avp_pkg::SCR_W-1:0]        out_screen_x,
  output logic signed [avp_pkg::SCR_W-1:0]        out_screen_y,
  output logic                                    out_behind_view,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [avp_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [avp_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import avp_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SCR_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (SCR_W - 1));

  // Configuration registers
  logic signed [COORD_WIDTH-1:0] off_x_r, off_y_r, off_z_r;
  logic [PPR_W-1:0]              ppr_r;
  logic [CTR_W-1:0]              ctr_x_r, ctr_y_r;

  // Stage 1: offset-corrected coordinates
  logic                     v1_r;
  logic signed [DIFF_W-1:0] d_r [3];
  logic signed [DIFF_W-1:0] d_nxt [3];

  // Stage 2: magnitudes and flags
  logic             v2_r;
  logic [MAG_W-1:0] an2_r [2];
  logic [MAG_W-1:0] an2_nxt [2];
  logic [MAG_W-1:0] ad2_r, ad2_nxt;
  side_t            s2_r, s2_nxt;

  // Stage 3: normalizing shift counts
  logic             v3_r;
  logic [MAG_W-1:0] an3_r [2];
  logic [MAG_W-1:0] ad3_r;
  logic [SH_W-1:0]  sh3_r [2];
  logic [SH_W-1:0]  sh3_nxt [2];
  side_t            s3_r;

  // CORDIC pipeline: index 0 holds the normalized start vector
  logic                    cv_r [CORDIC_STEPS+1];
  side_t                   cs_r [CORDIC_STEPS+1];
  logic signed [CW-1:0]    cx_r   [CORDIC_STEPS+1][2];
  logic signed [CW-1:0]    cy_r   [CORDIC_STEPS+1][2];
  logic signed [ANG_W-1:0] cz_r   [CORDIC_STEPS+1][2];
  logic signed [CW-1:0]    cx_nxt [CORDIC_STEPS+1][2];
  logic signed [CW-1:0]    cy_nxt [CORDIC_STEPS+1][2];
  logic signed [ANG_W-1:0] cz_nxt [CORDIC_STEPS+1][2];

  // Angle select, multiply and output stages
  logic                     v5_r;
  logic signed [AW1-1:0]    ang_r [2];
  logic signed [AW1-1:0]    ang_nxt [2];
  logic                     b5_r;
  logic                     v6_r;
  logic signed [PROD_W-1:0] prod_r [2];
  logic signed [PROD_W-1:0] prod_nxt [2];
  logic                     b6_r;
  logic                     out_valid_r;
  logic signed [SCR_W-1:0]  scr_r [2];
  logic signed [SCR_W-1:0]  scr_nxt [2];
  logic                     behind_r;

  assign busy            = 1'b0;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_screen_x    = scr_r[0];
  assign out_screen_y    = scr_r[1];
  assign out_behind_view = behind_r;

  // Take configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= COORD_WIDTH'(OFFSET_Z_RST);
      ppr_r   <= PPR_W'(PPR_RST);
      ctr_x_r <= CTR_W'(CENTER_X_RST);
      ctr_y_r <= CTR_W'(CENTER_Y_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_X: off_x_r <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Y: off_y_r <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Z: off_z_r <= cfg_data[COORD_WIDTH-1:0];
        REG_PPR:      ppr_r   <= cfg_data[PPR_W-1:0];
        REG_CENTER_X: ctr_x_r <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y: ctr_y_r <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: add the object-minus-camera offset
  always_comb begin
    d_nxt[0] = DIFF_W'(in_vert_x) + DIFF_W'(off_x_r);
    d_nxt[1] = DIFF_W'(in_vert_y) + DIFF_W'(off_y_r);
    d_nxt[2] = DIFF_W'(in_vert_z) + DIFF_W'(off_z_r);
  end

  // Stage 2: take magnitudes, record signs and zero cases
  always_comb begin
    logic             den_neg;
    logic             num_neg;
    logic [DIFF_W-1:0] t;
    den_neg            = d_r[2][DIFF_W-1];
    t                  = den_neg ? DIFF_W'(-d_r[2]) : DIFF_W'(d_r[2]);
    ad2_nxt            = MAG_W'(t);
    s2_nxt.zero_den    = (d_r[2] == '0);
    s2_nxt.behind      = den_neg || (d_r[2] == '0);
    for (int l = 0; l < 2; l++) begin
      num_neg                 = d_r[l][DIFF_W-1];
      t                       = num_neg ? DIFF_W'(-d_r[l]) : DIFF_W'(d_r[l]);
      an2_nxt[l]              = MAG_W'(t);
      s2_nxt.lane[l].zero_num = (d_r[l] == '0);
      s2_nxt.lane[l].num_neg  = num_neg;
      s2_nxt.lane[l].flip     = num_neg ^ den_neg;
    end
  end

  // Stage 3: count left shifts until either magnitude reaches one in Q30
  always_comb begin
    logic [MAG_W-1:0] m;
    for (int l = 0; l < 2; l++) begin
      m          = an2_r[l] | ad2_r;
      sh3_nxt[l] = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
        if (m[k]) begin
          sh3_nxt[l] = SH_W'(FRAC_BITS - k);
        end
      end
      if (m[MAG_W-1:FRAC_BITS] != '0) begin
        sh3_nxt[l] = '0;
      end
    end
  end

  // Stage 4 and CORDIC iterations: rotate each vector toward the x axis
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cx_nxt[0][l] = CW'(MAG_W'(ad3_r << sh3_r[l]));
      cy_nxt[0][l] = CW'(MAG_W'(an3_r[l] << sh3_r[l]));
      cz_nxt[0][l] = '0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      for (int l = 0; l < 2; l++) begin
        if (!cy_r[i][l][CW-1]) begin
          cx_nxt[i+1][l] = cx_r[i][l] + (cy_r[i][l] >>> i);
          cy_nxt[i+1][l] = cy_r[i][l] - (cx_r[i][l] >>> i);
          cz_nxt[i+1][l] = cz_r[i][l] + signed'(ATAN_TAB[i]);
        end else begin
          cx_nxt[i+1][l] = cx_r[i][l] - (cy_r[i][l] >>> i);
          cy_nxt[i+1][l] = cy_r[i][l] + (cx_r[i][l] >>> i);
          cz_nxt[i+1][l] = cz_r[i][l] - signed'(ATAN_TAB[i]);
        end
      end
    end
  end

  // Angle select: zero, right angle or CORDIC angle; the row angle is negated here
  always_comb begin
    logic signed [AW1-1:0] v;
    logic                  flip;
    lane_flag_t            f;
    for (int l = 0; l < 2; l++) begin
      f = cs_r[CORDIC_STEPS].lane[l];
      if (cs_r[CORDIC_STEPS].zero_den) begin
        v    = AW1'(HALF_PI_Q30);
        flip = f.num_neg;
      end else begin
        v    = AW1'(cz_r[CORDIC_STEPS][l]);
        flip = f.flip;
      end
      if (l == 1) begin
        flip = !flip;
      end
      if (f.zero_num) begin
        ang_nxt[l] = '0;
      end else begin
        ang_nxt[l] = flip ? -v : v;
      end
    end
  end

  // Scale by pixels per radian
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod_nxt[l] = PROD_W'(ang_r[l] * signed'({1'b0, ppr_r}));
    end
  end

  // Floor to whole pixels, add the centre and saturate
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic [CTR_W-1:0]        ctr;
    for (int l = 0; l < 2; l++) begin
      ctr = (l == 0) ? ctr_x_r : ctr_y_r;
      sum = SUM_W'(signed'(prod_r[l][PROD_W-1:FRAC_BITS])) + SUM_W'({1'b0, ctr});
      if (sum > SAT_HI) begin
        scr_nxt[l] = SAT_HI[SCR_W-1:0];
      end else if (sum < SAT_LO) begin
        scr_nxt[l] = SAT_LO[SCR_W-1:0];
      end else begin
        scr_nxt[l] = sum[SCR_W-1:0];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        cv_r[i] <= 1'b0;
      end
    end else begin
      v1_r    <= start && !busy;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      cv_r[0] <= v3_r;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cv_r[i+1] <= cv_r[i];
      end
      v5_r        <= cv_r[CORDIC_STEPS];
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    an2_r    <= an2_nxt;
    ad2_r    <= ad2_nxt;
    s2_r     <= s2_nxt;
    an3_r    <= an2_r;
    ad3_r    <= ad2_r;
    sh3_r    <= sh3_nxt;
    s3_r     <= s2_r;
    cs_r[0]  <= s3_r;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      cs_r[i+1] <= cs_r[i];
    end
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cz_r     <= cz_nxt;
    ang_r    <= ang_nxt;
    b5_r     <= cs_r[CORDIC_STEPS].behind;
    prod_r   <= prod_nxt;
    b6_r     <= b5_r;
    scr_r    <= scr_nxt;
    behind_r <= b6_r;
  end

endmodule

`default_nettype wire

### rtl/avp_checker.sv
`default_nettype none

module avp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);
  import avp_pkg::*;

  // Every accepted request yields a result strobe, timed by LATENCY
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request produced no result at the expected latency");

  // No result strobe without a matching accepted request, timed by LATENCY
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  // Reset flushes the pipeline
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  // The pipeline never holds requests off
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind angular_vertex_projection_unit avp_checker u_avp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire
